### sv/renc_pkg.sv
// Shared types and constants for the rotary encoder and push button decoder.
`default_nettype none

package renc_pkg;

    localparam int unsigned PosW     = 8;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned LongW    = 16;
    localparam int unsigned DirW     = 2;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    // step direction codes
    localparam logic [DirW-1:0] DIR_NONE = 2'd0;
    localparam logic [DirW-1:0] DIR_CW   = 2'd1;
    localparam logic [DirW-1:0] DIR_CCW  = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_POS_MIN  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_POS_MAX  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LONG_MS  = 2'd2;

    localparam logic [PosW-1:0]  POS_MIN_RST = 8'd0;
    localparam logic [PosW-1:0]  POS_MAX_RST = 8'd255;
    localparam logic [LongW-1:0] LONG_MS_RST = 16'd1000;

    typedef struct packed {
        logic             kind;
        logic             a_level;
        logic             b_level;
        logic             switch_level;
        logic [TimeW-1:0] now_ms;
        logic [PosW-1:0]  load_value;
        logic             restart_long;
    } t_in_item;

    typedef struct packed {
        logic [PosW-1:0]  position;
        logic [DirW-1:0]  direction;
        logic             button_held;
        logic             press_event;
        logic [TimeW-1:0] down_time;
        logic             long_press;
        logic             changed;
    } t_out_item;

    typedef struct packed {
        logic [PosW-1:0]  pos_min;
        logic [PosW-1:0]  pos_max;
        logic [LongW-1:0] long_ms;
    } t_cfg;

endpackage

`default_nettype wire

### sv/renc_ifs.sv
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface renc_in_if
    import renc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic             a_level;
    logic             b_level;
    logic             switch_level;
    logic [TimeW-1:0] now_ms;
    logic [PosW-1:0]  load_value;
    logic             restart_long;

    modport source (
        output valid, kind, a_level, b_level, switch_level, now_ms, load_value,
               restart_long,
        input  ready
    );
    modport sink (
        input  valid, kind, a_level, b_level, switch_level, now_ms, load_value,
               restart_long,
        output ready
    );
endinterface

interface renc_out_if
    import renc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PosW-1:0]  position;
    logic [DirW-1:0]  direction;
    logic             button_held;
    logic             press_event;
    logic [TimeW-1:0] down_time;
    logic             long_press;
    logic             changed;

    modport source (
        output valid, position, direction, button_held, press_event, down_time,
               long_press, changed,
        input  ready
    );
    modport sink (
        input  valid, position, direction, button_held, press_event, down_time,
               long_press, changed,
        output ready
    );
endinterface

interface renc_cfg_if
    import renc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### sv/rotary_encoder_with_button_core.sv
// Top level of the rotary encoder and push button decoder.
// Takes one item per clock cycle unless result back-pressure stalls it: each
// item is a pin sample (A, B, switch, millisecond timestamp) or a position
// load, and gives exactly one result item. An accepted item sits in the input
// register and is decoded into the result register at the edge where the
// decoder takes it; the encoder and switch state update at that same edge,
// which lets the following item be decoded right behind it.
// Back-pressure on the result side stalls the input side only when both
// registers are full. Configuration writes are always ready and should be
// made while no item is in flight.
`default_nettype none

module rotary_encoder_with_button_core
    import renc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    renc_in_if.sink     i_in,
    renc_out_if.source  o_out,
    renc_cfg_if.sink    i_cfg
);

    t_cfg      cfg;
    t_in_item  in_item;
    t_in_item  stage_item;
    t_out_item out_item;
    logic      stage_valid;
    logic      stage_take;

    assign in_item.kind         = i_in.kind;
    assign in_item.a_level      = i_in.a_level;
    assign in_item.b_level      = i_in.b_level;
    assign in_item.switch_level = i_in.switch_level;
    assign in_item.now_ms       = i_in.now_ms;
    assign in_item.load_value   = i_in.load_value;
    assign in_item.restart_long = i_in.restart_long;

    renc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (cfg)
    );

    renc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (i_in.ready),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (stage_take)
    );

    renc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (stage_valid),
        .i_item  (stage_item),
        .o_take  (stage_take),
        .o_valid (o_out.valid),
        .o_item  (out_item),
        .i_ready (o_out.ready)
    );

    assign o_out.position    = out_item.position;
    assign o_out.direction   = out_item.direction;
    assign o_out.button_held = out_item.button_held;
    assign o_out.press_event = out_item.press_event;
    assign o_out.down_time   = out_item.down_time;
    assign o_out.long_press  = out_item.long_press;
    assign o_out.changed     = out_item.changed;

endmodule

`default_nettype wire

### sv/renc_cfg_regs.sv
// Configuration registers: position limits and long press time.
`default_nettype none

module renc_cfg_regs
    import renc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [CfgIdxW-1:0]  i_index,
    input  wire logic [CfgDataW-1:0] i_data,
    output logic                     o_ready,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_min <= POS_MIN_RST;
            r_cfg.pos_max <= POS_MAX_RST;
            r_cfg.long_ms <= LONG_MS_RST;
        end else if (i_valid) begin
            case (i_index)
                CFG_POS_MIN: r_cfg.pos_min <= i_data[PosW-1:0];
                CFG_POS_MAX: r_cfg.pos_max <= i_data[PosW-1:0];
                CFG_LONG_MS: r_cfg.long_ms <= i_data[LongW-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/renc_in_reg.sv
// Input register stage with pass-through ready.
`default_nettype none

module renc_in_reg
    import renc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_ready,
    output logic          o_valid,
    output t_in_item      o_item,
    input  wire logic     i_take
);

    logic     r_valid;
    t_in_item r_item;

    // slot frees up in the same cycle the decoder takes the held item
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### sv/renc_decode.sv
// Encoder and switch state, per-item decode logic and result register.
`default_nettype none

module renc_decode
    import renc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_take,
    output logic          o_valid,
    output t_out_item     o_item,
    input  wire logic     i_ready
);

    logic             r_last_a;
    logic             r_last_sw;
    logic             r_held;
    logic [TimeW-1:0] r_start;
    logic [PosW-1:0]  r_pos;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             n_last_a;
    logic             n_last_sw;
    logic             n_held;
    logic [TimeW-1:0] n_start;
    logic [PosW-1:0]  n_pos;
    t_out_item        n_out;

    logic [TimeW-1:0] start_sw;
    logic [TimeW-1:0] long_deadline;
    logic             is_long;
    logic             take;

    assign take    = i_valid && (!r_out_valid || i_ready);
    assign o_take  = take;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        n_last_a              = r_last_a;
        n_last_sw             = r_last_sw;
        n_held                = r_held;
        n_pos                 = r_pos;
        start_sw              = r_start;
        n_out.direction       = DIR_NONE;
        n_out.press_event     = 1'b0;
        n_out.changed         = 1'b0;

        if (i_item.kind == KIND_LOAD) begin
            n_pos = i_item.load_value;
        end else begin
            if (i_item.switch_level != r_last_sw) begin
                if (i_item.switch_level) begin
                    n_held   = 1'b1;
                    start_sw = i_item.now_ms;
                end else begin
                    n_held            = 1'b0;
                    n_out.press_event = 1'b1;
                    start_sw          = '0;
                end
                n_last_sw     = i_item.switch_level;
                n_out.changed = 1'b1;
            end
            if (!r_last_a && i_item.a_level) begin
                // B low on rising A: clockwise, count down
                if (!i_item.b_level) begin
                    if (r_pos > i_cfg.pos_min) begin
                        n_pos           = r_pos - PosW'(1);
                        n_out.direction = DIR_CW;
                    end
                end else begin
                    if (r_pos < i_cfg.pos_max) begin
                        n_pos           = r_pos + PosW'(1);
                        n_out.direction = DIR_CCW;
                    end
                end
                n_out.changed = 1'b1;
            end
            n_last_a = i_item.a_level;
        end

        // timing uses the press start after the switch update, before restart
        long_deadline     = start_sw + {{(TimeW-LongW){1'b0}}, i_cfg.long_ms};
        is_long           = long_deadline < i_item.now_ms;
        n_out.down_time   = i_item.now_ms - start_sw;
        n_out.long_press  = is_long;
        n_start           = (is_long && i_item.restart_long) ? i_item.now_ms : start_sw;
        n_out.position    = n_pos;
        n_out.button_held = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a    <= 1'b0;
            r_last_sw   <= 1'b0;
            r_held      <= 1'b0;
            r_start     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_last_a    <= n_last_a;
                r_last_sw   <= n_last_sw;
                r_held      <= n_held;
                r_start     <= n_start;
                r_pos       <= n_pos;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### sv/renc_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none

module renc_checker
    import renc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic [PosW-1:0]  i_position,
    input  wire logic [DirW-1:0]  i_direction,
    input  wire logic             i_button_held,
    input  wire logic             i_press_event,
    input  wire logic [TimeW-1:0] i_down_time,
    input  wire logic             i_long_press,
    input  wire logic             i_changed
);

    // a step always comes from an A edge, which marks the item as changed
    a_step_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_direction != DIR_NONE) |-> i_changed)
        else $error("step reported without change flag");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_direction == DIR_NONE || i_direction == DIR_CW ||
                         i_direction == DIR_CCW))
        else $error("invalid direction code");

    // release pulse only on the sample that lets go of the switch
    a_event_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_press_event |-> !i_button_held && i_changed)
        else $error("press event while held or without change");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_position) &&
            $stable(i_direction) && $stable(i_button_held) &&
            $stable(i_press_event) && $stable(i_down_time) &&
            $stable(i_long_press) && $stable(i_changed))
        else $error("stalled result item changed");

endmodule

bind rotary_encoder_with_button_core renc_checker u_renc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_position    (o_out.position),
    .i_direction   (o_out.direction),
    .i_button_held (o_out.button_held),
    .i_press_event (o_out.press_event),
    .i_down_time   (o_out.down_time),
    .i_long_press  (o_out.long_press),
    .i_changed     (o_out.changed)
);

`default_nettype wire
